@@ sv/smf_pkg.sv @@
// Shared constants, payload types and lane control type of the sliding median filter.
`default_nettype none

package smf_pkg;

	localparam int WINDOW_DEPTH = 8;
	localparam int SAMPLE_BITS  = 12;
	localparam int LEVEL_BITS   = 8;
	localparam int IDX_W        = $clog2(WINDOW_DEPTH);
	localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
	localparam int MID          = WINDOW_DEPTH / 2;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] throttle_sample;
		logic [SAMPLE_BITS-1:0] steering_sample;
	} in_t;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] throttle_level;
		logic [LEVEL_BITS-1:0] steering_level;
	} out_t;

	typedef struct packed {
		logic             wr_en;
		logic             rank_en;
		logic [IDX_W-1:0] pos;
		logic [IDX_W-1:0] idx;
	} lane_ctrl_t;

endpackage

`default_nettype wire

@@ sv/smf_lane.sv @@
// One channel's sample window and its sequential rank search for the upper median.
`default_nettype none

module smf_lane (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire smf_pkg::lane_ctrl_t              ctrl,
	input  wire logic [smf_pkg::SAMPLE_BITS-1:0]  wr_data,
	output logic      [smf_pkg::SAMPLE_BITS-1:0]  median
);

	logic [smf_pkg::SAMPLE_BITS-1:0] window_q [smf_pkg::WINDOW_DEPTH];
	logic [smf_pkg::SAMPLE_BITS-1:0] median_q;
	logic [smf_pkg::SAMPLE_BITS-1:0] cand;
	logic [smf_pkg::CNT_W-1:0]       less_cnt;
	logic [smf_pkg::CNT_W-1:0]       eq_cnt;
	logic                            hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < smf_pkg::WINDOW_DEPTH; i++) begin
				window_q[i] <= '0;
			end
		end else if (ctrl.wr_en) begin
			window_q[ctrl.pos] <= wr_data;
		end
	end

	always_comb begin
		cand     = window_q[ctrl.idx];
		less_cnt = '0;
		eq_cnt   = '0;
		for (int i = 0; i < smf_pkg::WINDOW_DEPTH; i++) begin
			less_cnt = less_cnt + smf_pkg::CNT_W'(window_q[i] < cand);
			eq_cnt   = eq_cnt + smf_pkg::CNT_W'(window_q[i] == cand);
		end
		hit = (less_cnt <= smf_pkg::CNT_W'(smf_pkg::MID)) &&
			(smf_pkg::CNT_W'(smf_pkg::MID) < (less_cnt + eq_cnt));
	end

	always_ff @(posedge clk) begin
		if (ctrl.rank_en && hit) begin
			median_q <= cand;
		end
	end

	assign median = median_q;

endmodule

`default_nettype wire

@@ sv/smf_merge.sv @@
// Merging stage: scales both lane medians to eight bits and holds the result transaction.
`default_nettype none

module smf_merge (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            load,
	input  wire logic [smf_pkg::SAMPLE_BITS-1:0] throttle_median,
	input  wire logic [smf_pkg::SAMPLE_BITS-1:0] steering_median,
	input  wire logic                            level_stall,
	output logic                                 level_valid,
	output smf_pkg::out_t                        level
);

	localparam int PROD_W = smf_pkg::SAMPLE_BITS + smf_pkg::LEVEL_BITS;

	function automatic logic [smf_pkg::LEVEL_BITS-1:0] scale(
		input logic [smf_pkg::SAMPLE_BITS-1:0] m
	);
		logic [PROD_W-1:0] prod;
		logic [PROD_W:0]   sum;
		prod = (PROD_W'(m) << smf_pkg::LEVEL_BITS) - PROD_W'(m);
		sum  = (PROD_W+1)'(prod) + (PROD_W+1)'(prod >> smf_pkg::SAMPLE_BITS) + (PROD_W+1)'(1);
		return smf_pkg::LEVEL_BITS'(sum >> smf_pkg::SAMPLE_BITS);
	endfunction

	logic          valid_q;
	smf_pkg::out_t level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!level_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			level_q.throttle_level <= scale(throttle_median);
			level_q.steering_level <= scale(steering_median);
		end
	end

	assign level_valid = valid_q;
	assign level       = level_q;

endmodule

`default_nettype wire

@@ sv/sliding_median_filter_core.sv @@
// Top level of the two-channel sliding median filter: control sequencer, lanes and merge.
//
//   Channel  Direction  Handshake                   Payload
//   sample   in         sample_valid / sample_stall  smf_pkg::in_t  (two 12-bit samples)
//   level    out        level_valid / level_stall    smf_pkg::out_t (two 8-bit levels)
//
// A sample transaction is a write, WINDOW_DEPTH ranking steps in each lane (one window entry
// is ranked per cycle) and a scale into the output register.
// A new sample is taken once the previous result is loaded, even while that result waits.
// Reset clears both windows, the write position and the sequencer.
// While the output register is full and stalled, a finished median waits in the merge state.
`default_nettype none

module sliding_median_filter_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          sample_valid,
	output logic               sample_stall,
	input  wire smf_pkg::in_t  sample,
	output logic               level_valid,
	input  wire logic          level_stall,
	output smf_pkg::out_t      level
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RANK  = 3'b010,
		ST_MERGE = 3'b100
	} state_t;

	state_t                         state_q;
	logic [smf_pkg::IDX_W-1:0]      pos_q;
	logic [smf_pkg::IDX_W-1:0]      idx_q;
	logic                           accept;
	logic                           last_idx;
	logic                           load;
	smf_pkg::lane_ctrl_t            ctrl;
	logic [smf_pkg::SAMPLE_BITS-1:0] throttle_median;
	logic [smf_pkg::SAMPLE_BITS-1:0] steering_median;

	assign sample_stall = (state_q != ST_IDLE);
	assign accept       = sample_valid && !sample_stall;
	assign last_idx     = (idx_q == smf_pkg::IDX_W'(smf_pkg::WINDOW_DEPTH - 1));
	assign load         = (state_q == ST_MERGE) && (!level_valid || !level_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RANK;
						idx_q   <= '0;
						pos_q   <= (pos_q == smf_pkg::IDX_W'(smf_pkg::WINDOW_DEPTH - 1)) ?
							'0 : pos_q + smf_pkg::IDX_W'(1);
					end
				end
				ST_RANK: begin
					idx_q <= idx_q + smf_pkg::IDX_W'(1);
					if (last_idx) begin
						state_q <= ST_MERGE;
					end
				end
				ST_MERGE: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		ctrl.wr_en   = accept;
		ctrl.rank_en = (state_q == ST_RANK);
		ctrl.pos     = pos_q;
		ctrl.idx     = idx_q;
	end

	smf_lane u_throttle (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.wr_data (sample.throttle_sample),
		.median  (throttle_median)
	);

	smf_lane u_steering (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.wr_data (sample.steering_sample),
		.median  (steering_median)
	);

	smf_merge u_merge (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (load),
		.throttle_median (throttle_median),
		.steering_median (steering_median),
		.level_stall     (level_stall),
		.level_valid     (level_valid),
		.level           (level)
	);

`ifndef SYNTH
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state is not one-hot");

	a_rank_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RANK) && (idx_q == '0))
		else $error("ranking did not start from the first entry");

	a_load_after_rank: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(level_valid) |-> $past(state_q == ST_MERGE))
		else $error("result appeared without a finished ranking pass");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= smf_pkg::IDX_W'(smf_pkg::WINDOW_DEPTH - 1))
		else $error("write position out of range");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RANK) |-> !accept)
		else $error("sample transaction taken while ranking");
`endif

endmodule

`default_nettype wire
